/* src/bnp_pkg.sv */
package bnp_pkg;

  // Field widths
  localparam int CH_W       = 8;
  localparam int RADIX_W    = 6;
  localparam int DIG_W      = 6;
  localparam int STATUS_W   = 2;
  localparam int VALUE_W    = 32;
  localparam int CONS_W     = 16;
  localparam int MAG_W      = 63;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  // Parse phases
  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 1'b1;

  // Base handling
  localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;

  // Character codes
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CH_W-1:0] LETTER_OFS = 8'd10;

  // Decoded character
  typedef struct packed {
    logic             is_digit;
    logic             is_space;
    logic             is_sign;
    logic             is_minus;
    logic [DIG_W-1:0] val;
  } char_class_t;

  // One result word
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] value;
    logic [CONS_W-1:0]         consumed;
  } result_t;

endpackage

/* src/bnp_in_if.sv */
interface bnp_in_if;
  import bnp_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

/* src/bnp_out_if.sv */
interface bnp_out_if;
  import bnp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] value;
  logic [CONS_W-1:0]         consumed;

  modport source (output valid, output status, output value, output consumed, input ready);
  modport sink   (input valid, input status, input value, input consumed, output ready);
endinterface

/* src/bnp_digit.sv */
module bnp_digit (
  input  logic [bnp_pkg::CH_W-1:0]    ch,
  input  logic [bnp_pkg::RADIX_W-1:0] radix,
  input  logic                        upper,
  output logic [bnp_pkg::RADIX_W-1:0] base,
  output bnp_pkg::char_class_t        cls
);
  import bnp_pkg::*;

  logic             in_set;
  logic [DIG_W-1:0] val;

  // Out-of-range bases fall back to decimal
  assign base = (radix < RADIX_MIN || radix > RADIX_MAX) ? RADIX_DEFAULT : radix;

  // Digit value in the selected letter case
  always_comb begin
    in_set = 1'b0;
    val    = '0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      in_set = 1'b1;
      val    = DIG_W'(ch - CH_ZERO);
    end else if (upper && ch >= CH_UP_A && ch <= CH_UP_Z) begin
      in_set = 1'b1;
      val    = DIG_W'(ch - CH_UP_A + LETTER_OFS);
    end else if (!upper && ch >= CH_LO_A && ch <= CH_LO_Z) begin
      in_set = 1'b1;
      val    = DIG_W'(ch - CH_LO_A + LETTER_OFS);
    end
  end

  assign cls.is_digit = in_set && (val < base);
  assign cls.val      = val;
  assign cls.is_space = (ch >= CH_TAB && ch <= CH_CR) || (ch == CH_SPACE);
  assign cls.is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
  assign cls.is_minus = (ch == CH_MINUS);

endmodule

/* src/bnp_acc.sv */
module bnp_acc #(
  parameter int MAX_CHARS = 65535
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        term,
  input  bnp_pkg::char_class_t        cls,
  input  logic [bnp_pkg::RADIX_W-1:0] base,
  output bnp_pkg::result_t            res
);
  import bnp_pkg::*;

  localparam int PW = $clog2(longint'(MAX_CHARS) + 1);
  localparam int PRODW = MAG_W + RADIX_W;

  logic [1:0]          phase_r, phase_nxt;
  logic [MAG_W-1:0]    mag_r, mag_nxt;
  logic                neg_r, neg_nxt;
  logic                any_r, any_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [STATUS_W-1:0] hst_r, hst_nxt;
  logic [PW-1:0]       hcons_r, hcons_nxt;

  logic [PW-1:0]       pos_inc;
  logic [PRODW-1:0]    prod;
  logic                acc_ovf;
  logic [STATUS_W-1:0] settle_st;
  logic [STATUS_W-1:0] st;
  logic [PW-1:0]       cons_w;
  logic [VALUE_W-1:0]  mag_lo;

  // Saturating character position
  assign pos_inc = (pos_r < PW'(MAX_CHARS)) ? pos_r + 1'b1 : pos_r;

  // Multiply-accumulate; any bit above the 63-bit range is an overflow
  assign prod    = (PRODW'(mag_r) * PRODW'(base)) + PRODW'(cls.val);
  assign acc_ovf = |prod[PRODW-1:MAG_W];

  // Outcome at the first non-digit
  always_comb begin
    if (!any_r) begin
      settle_st = ST_INVALID;
    end else if (neg_r ? (mag_r > MAG_W'(64'h8000_0000)) : (mag_r > MAG_W'(64'h7FFF_FFFF))) begin
      settle_st = ST_OVERFLOW;
    end else begin
      settle_st = ST_OK;
    end
  end

  // Parse state update
  always_comb begin
    logic dig;
    dig       = 1'b0;
    phase_nxt = phase_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    any_nxt   = any_r;
    pos_nxt   = pos_r;
    hst_nxt   = hst_r;
    hcons_nxt = hcons_r;
    if (step) begin
      if (term) begin
        phase_nxt = PH_SKIP;
        mag_nxt   = '0;
        neg_nxt   = 1'b0;
        any_nxt   = 1'b0;
        pos_nxt   = '0;
        hst_nxt   = ST_OK;
        hcons_nxt = '0;
      end else begin
        case (phase_r)
          PH_SKIP: begin
            if (cls.is_space) begin
              pos_nxt = pos_inc;
            end else if (cls.is_sign) begin
              neg_nxt   = cls.is_minus;
              pos_nxt   = pos_inc;
              phase_nxt = PH_DIGITS;
            end else begin
              dig = 1'b1;
            end
          end
          PH_DIGITS: dig = 1'b1;
          default: ;
        endcase
        if (dig) begin
          if (!cls.is_digit) begin
            phase_nxt = PH_DONE;
            hst_nxt   = settle_st;
            hcons_nxt = pos_r;
          end else if (acc_ovf) begin
            phase_nxt = PH_DONE;
            hst_nxt   = ST_OVERFLOW;
            hcons_nxt = pos_r;
          end else begin
            phase_nxt = PH_DIGITS;
            mag_nxt   = prod[MAG_W-1:0];
            any_nxt   = 1'b1;
            pos_nxt   = pos_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      mag_r   <= '0;
      neg_r   <= 1'b0;
      any_r   <= 1'b0;
      pos_r   <= '0;
      hst_r   <= ST_OK;
      hcons_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      any_r   <= any_nxt;
      pos_r   <= pos_nxt;
      hst_r   <= hst_nxt;
      hcons_r <= hcons_nxt;
    end
  end

  // Result for a terminating zero in the current phase
  always_comb begin
    case (phase_r)
      PH_SKIP: begin
        st     = ST_INVALID;
        cons_w = '0;
      end
      PH_DIGITS: begin
        st     = settle_st;
        cons_w = pos_r;
      end
      default: begin
        st     = hst_r;
        cons_w = hcons_r;
      end
    endcase
  end

  assign mag_lo       = mag_r[VALUE_W-1:0];
  assign res.status   = st;
  assign res.value    = (st == ST_OK) ? (neg_r ? -mag_lo : mag_lo) : '0;
  assign res.consumed = (32'(cons_w) > 32'h0000_FFFF) ? {CONS_W{1'b1}} : CONS_W'(cons_w);

endmodule

/* src/base_n_integer_parser.sv */
// Streaming integer parser: one character word per cycle, sustained, including
// back to back strings. Leading white space and one sign are taken, then digits
// in the configured radix (2 to 36, otherwise 10) until the first non-digit; the
// result word (status, value, consumed) is issued for the terminating zero byte,
// passing through the input register and then the output register. The per-cycle
// limit is the accumulator update, a 63 by 6 bit multiply-add with its overflow
// compare, done once per character between the input register and the parse
// state. Input words keep flowing while a result waits; only a second zero byte
// stalls behind an untaken result. Write radix and upper_letters only while idle.
module base_n_integer_parser #(
  parameter int MAX_CHARS = 65535
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bnp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bnp_pkg::CFG_DATA_W-1:0] cfg_data,
  bnp_in_if.sink                         in_if,
  bnp_out_if.source                      out_if
);
  import bnp_pkg::*;

  logic [RADIX_W-1:0] radix_r;
  logic               upper_r;
  logic               stg_v_r;
  logic [CH_W-1:0]    stg_ch_r;
  logic               out_v_r;
  result_t            out_r;
  logic               term;
  logic               advance;
  logic [RADIX_W-1:0] base;
  char_class_t        cls;
  result_t            res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_DEFAULT;
      upper_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_RADIX: radix_r <= cfg_data[RADIX_W-1:0];
        CFG_UPPER: upper_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage word moves on unless it is a terminator blocked by a waiting result
  assign term        = (stg_ch_r == CH_NUL);
  assign advance     = stg_v_r && (!term || !out_v_r || out_if.ready);
  assign in_if.ready = !stg_v_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_if.ready) begin
      stg_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      stg_ch_r <= in_if.ch;
    end
  end

  bnp_digit u_digit (
    .ch    (stg_ch_r),
    .radix (radix_r),
    .upper (upper_r),
    .base  (base),
    .cls   (cls)
  );

  bnp_acc #(
    .MAX_CHARS (MAX_CHARS)
  ) u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .term  (term),
    .cls   (cls),
    .base  (base),
    .res   (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && term) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && term) begin
      out_r <= res;
    end
  end

  assign out_if.valid    = out_v_r;
  assign out_if.status   = out_r.status;
  assign out_if.value    = out_r.value;
  assign out_if.consumed = out_r.consumed;

endmodule

/* src/bnp_checker.sv */
module bnp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [bnp_pkg::CH_W-1:0]     in_ch,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bnp_pkg::STATUS_W-1:0] out_status,
  input logic [bnp_pkg::VALUE_W-1:0]  out_value,
  input logic [bnp_pkg::CONS_W-1:0]   out_consumed
);
  import bnp_pkg::*;

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_value)
      && $stable(out_consumed))
    else $error("result word changed while stalled");

  // A new result follows an accepted zero byte
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_ch == CH_NUL, 2))
    else $error("result without a terminating zero");

  // Failed parses report a zero value
  a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_value == '0)
    else $error("nonzero value on a failed parse");

  // A successful parse consumed at least one digit
  a_ok_cons: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_consumed != '0)
    else $error("success with nothing consumed");

endmodule

bind base_n_integer_parser bnp_checker u_bnp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .in_ch        (in_if.ch),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_status   (out_if.status),
  .out_value    (out_if.value),
  .out_consumed (out_if.consumed)
);

/* verif/base_n_integer_parser_tb.sv */
module base_n_integer_parser_tb;
  import bnp_pkg::*;

  localparam int MAX_CHARS      = 65535;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASES         = 14;
  localparam int PHASE_CHARS    = 40;
  localparam int LONG_RUN       = 300;
  localparam longint unsigned MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  // Predicts the result word of each string and keeps the words still owed
  class parse_scoreboard;
    logic [RADIX_W-1:0] radix;
    bit                 upper;
    logic [1:0]         phase;
    longint unsigned    mag;
    bit                 neg;
    bit                 any_dig;
    int unsigned        pos;
    logic [STATUS_W-1:0] held_st;
    int unsigned        held_cons;
    result_t            owed_q[$];
    int                 errors;

    function new();
      radix  = RADIX_DEFAULT;
      upper  = 1'b0;
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase     = PH_SKIP;
      mag       = 0;
      neg       = 1'b0;
      any_dig   = 1'b0;
      pos       = 0;
      held_st   = ST_OK;
      held_cons = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_RADIX) begin
        radix = data;
      end else begin
        upper = data[0];
      end
    endfunction

    // Out-of-range radix values fall back to decimal
    function int unsigned eff_base();
      return 32'((radix < RADIX_MIN || radix > RADIX_MAX) ? RADIX_DEFAULT : radix);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Digit value in the current base, -1 for anything else
    function int char_digit(logic [CH_W-1:0] c);
      int v;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        v = 32'(c - CH_ZERO);
      end else if (upper && c >= CH_UP_A && c <= CH_UP_Z) begin
        v = 32'(c - CH_UP_A + LETTER_OFS);
      end else if (!upper && c >= CH_LO_A && c <= CH_LO_Z) begin
        v = 32'(c - CH_LO_A + LETTER_OFS);
      end else begin
        return -1;
      end
      return (v < eff_base()) ? v : -1;
    endfunction

    function void bump();
      if (pos < MAX_CHARS) pos++;
    endfunction

    // First non-digit: outcome is fixed here
    function void settle();
      phase     = PH_DONE;
      held_cons = pos;
      if (!any_dig) begin
        held_st = ST_INVALID;
      end else if (neg ? (mag > 64'h8000_0000) : (mag > 64'h7FFF_FFFF)) begin
        held_st = ST_OVERFLOW;
      end else begin
        held_st = ST_OK;
      end
    endfunction

    function void take_digit(logic [CH_W-1:0] c);
      int d;
      longint unsigned dv;
      longint unsigned b;
      d = char_digit(c);
      b = 64'(eff_base());
      if (d < 0) begin
        settle();
        return;
      end
      dv = 64'(d);
      // accumulator would pass 2^63-1
      if (mag > (MAG_LIMIT - dv) / b) begin
        phase     = PH_DONE;
        held_st   = ST_OVERFLOW;
        held_cons = pos;
        return;
      end
      mag     = mag * b + dv;
      any_dig = 1'b1;
      bump();
    endfunction

    function void note_char(logic [CH_W-1:0] c);
      result_t     r;
      logic [31:0] lo;
      if (c == CH_NUL) begin
        r = '0;
        if (phase == PH_SKIP) begin
          r.status = ST_INVALID;
        end else begin
          if (phase == PH_DIGITS) settle();
          r.status   = held_st;
          r.consumed = (held_cons > 16'hFFFF) ? 16'hFFFF : 16'(held_cons);
          if (held_st == ST_OK) begin
            lo      = mag[31:0];
            r.value = neg ? -lo : lo;
          end
        end
        owed_q.push_back(r);
        clear();
        return;
      end
      case (phase)
        PH_SKIP: begin
          if ((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE) begin
            bump();
          end else if (c == CH_MINUS || c == CH_PLUS) begin
            neg = (c == CH_MINUS);
            bump();
            phase = PH_DIGITS;
          end else begin
            phase = PH_DIGITS;
            take_digit(c);
          end
        end
        PH_DIGITS: take_digit(c);
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (owed_q.size() == 0) begin
        $error("result word with none owed: status %0d value %0d consumed %0d",
               got.status, got.value, got.consumed);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status);
        errors++;
      end
      if (got.value !== e.value) begin
        $error("value: expected %0d, got %0d", e.value, got.value);
        errors++;
      end
      if (got.consumed !== e.consumed) begin
        $error("consumed: expected %0d, got %0d", e.consumed, got.consumed);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  bnp_in_if  in_if();
  bnp_out_if out_if();

  base_n_integer_parser DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_if    (in_if),
    .out_if   (out_if)
  );

  parse_scoreboard sb = new();

  bit              gaps_on;
  int              gap_odds;
  int              sent;
  int              quiet_cycles;
  logic [CH_W-1:0] text_q[$];

  logic [CFG_DATA_W-1:0] radix_set [12] = '{6'd10, 6'd2, 6'd36, 6'd36, 6'd16, 6'd0,
                                            6'd63, 6'd1, 6'd37, 6'd8, 6'd3, 6'd24};
  bit                    upper_set [12] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1,
                                            1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stall bursts while gaps are on
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(1, gap_odds) == 1) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Monitors
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) sb.note_char(in_if.ch);
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.status   = out_if.status;
      got.value    = out_if.value;
      got.consumed = out_if.consumed;
      sb.check_result(got);
    end
  end

  // Watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_char(logic [CH_W-1:0] c);
    @(negedge clk);
    if (gaps_on && $urandom_range(1, gap_odds) == 1) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    do @(posedge clk); while (!in_if.ready);
    sent++;
  endtask

  task automatic send_text();
    while (text_q.size() > 0) send_char(text_q.pop_front());
  endtask

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  // Stop sending and let every owed word come out
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CH_W-1:0] digit_char(int d);
    if (d < 10) return CH_W'(CH_ZERO + d);
    return CH_W'((sb.upper ? CH_UP_A : CH_LO_A) + d - LETTER_OFS);
  endfunction

  function automatic logic [CH_W-1:0] space_char();
    int r;
    r = $urandom_range(CH_TAB, CH_CR + 1);
    return (r > CH_CR) ? CH_SPACE : CH_W'(r);
  endfunction

  // One string: mostly well-formed numbers, some noise and broken ones
  function automatic void compose_string();
    int          kind;
    int          n;
    int          r;
    int unsigned b;
    b    = sb.eff_base();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      n = $urandom_range(0, 6);
      repeat (n) text_q.push_back(CH_W'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) text_q.push_back(space_char());
      end
      case ($urandom_range(0, 3))
        0: text_q.push_back(CH_MINUS);
        1: text_q.push_back(CH_PLUS);
        default: ;
      endcase
      r = $urandom_range(0, 9);
      if (kind < 17)  n = 0;
      else if (r < 6) n = $urandom_range(1, 8);
      else if (r < 8) n = $urandom_range(9, 12);
      else            n = $urandom_range(13, 70);
      repeat (n) text_q.push_back(digit_char($urandom_range(0, b - 1)));
      // trailing junk after the number
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) text_q.push_back(CH_W'($urandom_range(1, 255)));
      end
    end
    text_q.push_back(CH_NUL);
  endfunction

  task automatic run_random(int quota);
    int start;
    start = sent;
    while (sent - start < quota) begin
      compose_string();
      send_text();
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.ch    = CH_NUL;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_RADIX;
    cfg_data    = '0;
    rst_n       = 1'b0;
    gaps_on     = 1'b1;
    gap_odds    = 8;
    sent        = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty, blanks only, bare sign, int minimum, stop at non-digit
    text_q.push_back(CH_NUL);
    push_str(" \t");
    text_q.push_back(CH_NUL);
    push_str("\r+");
    text_q.push_back(CH_NUL);
    push_str("-2147483648");
    text_q.push_back(CH_NUL);
    push_str("7x");
    text_q.push_back(8'hFF);
    text_q.push_back(CH_NUL);
    send_text();

    // Random phases over a spread of radix and letter-case settings
    for (int k = 0; k < PHASES; k++) begin
      wait_idle();
      if (k < 12) begin
        write_reg(CFG_RADIX, radix_set[k]);
        write_reg(CFG_UPPER, CFG_DATA_W'(upper_set[k]));
      end else begin
        write_reg(CFG_RADIX, CFG_DATA_W'($urandom_range(0, 63)));
        write_reg(CFG_UPPER, CFG_DATA_W'($urandom_range(0, 1)));
      end
      gap_odds = $urandom_range(3, 24);
      run_random(PHASE_CHARS);
    end

    // Long strings: a long run of blanks, then a long run of leading zeros
    wait_idle();
    write_reg(CFG_RADIX, RADIX_DEFAULT);
    write_reg(CFG_UPPER, '0);
    gaps_on = 1'b0;
    repeat (LONG_RUN) send_char(CH_SPACE);
    send_char(CH_W'(CH_ZERO + 5));
    send_char(CH_NUL);
    repeat (LONG_RUN) send_char(CH_ZERO);
    send_char(CH_NINE);
    send_char(CH_NUL);

    // Last stretch at full rate on both sides
    run_random(150);
    wait_idle();

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
src/bnp_pkg.sv
src/bnp_in_if.sv
src/bnp_out_if.sv
src/bnp_digit.sv
src/bnp_acc.sv
src/base_n_integer_parser.sv
src/bnp_checker.sv
verif/base_n_integer_parser_tb.sv
